/* design/pfas_pkg.sv */
`timescale 1ns / 1ps
// Shared package for the pairwise flip assignment search.
// Holds field widths, default sizes and the entry and command types.
// No dependencies.
package pfas_pkg;

    // Default sizes of the group vector and the entry store
    localparam int MAX_GROUPS_DEF = 10;
    localparam int MAX_PAIRS_DEF  = 128;

    // Fixed field widths of the ports
    localparam int GROUP_W     = 4;
    localparam int COST_W      = 16;
    localparam int SCORE_W     = 32;
    localparam int OUT_MASK_W  = 10;
    localparam int CFG_W       = 4;
    localparam int MASK_EXT_W  = 1 << GROUP_W;
    localparam int PAIR_ADDR_W = 10;

    // One stored pair-cost entry
    typedef struct packed {
        logic [GROUP_W-1:0] first_group;
        logic [GROUP_W-1:0] second_group;
        logic [COST_W-1:0]  same_cost;
        logic [COST_W-1:0]  differ_cost;
    } pfas_entry_t;

    localparam int ENTRY_W = $bits(pfas_entry_t);

    // Classified transaction handed from the front end to the back end
    typedef struct packed {
        pfas_entry_t            entry;
        logic                   last_entry;
        logic                   store_ok;
        logic [PAIR_ADDR_W-1:0] addr;
    } pfas_cmd_t;

endpackage

/* design/pairwise_flip_assignment_search.sv */
`timescale 1ns / 1ps
// Top level of the pairwise flip assignment search.
// Channel     | signals                                      | direction
// ------------+----------------------------------------------+-----------
// cfg write   | cfg_valid, cfg_ready, cfg_data (group_count) | in
// pair input  | in_valid, in_stall, first_group ... last_entry| in
// result      | out_valid, out_stall, flip_mask, best_score  | out
//
// An entry is stored in the back-end cycle that pops it; the two-slot queue lets the
// front take entries while the back end is busy. A closing entry with n
// groups searches 2^(n-1) vectors, each by one store read per stored entry,
// a sum of the registered read data and one compare, after the cycle
// that pops it from the queue. With one group the result shows the cycle
// after the pop.
// Reset clears control state only; the pair store needs no clearing.
// Input stalls whenever the queue is full; a held result blocks the back end.
// Depends on pfas_pkg, pfas_front, pfas_fifo, pfas_ram and pfas_back.
module pairwise_flip_assignment_search #(
    parameter int MAX_GROUPS = pfas_pkg::MAX_GROUPS_DEF,
    parameter int MAX_PAIRS  = pfas_pkg::MAX_PAIRS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfas_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pfas_pkg::GROUP_W-1:0]     first_group,
    input  logic [pfas_pkg::GROUP_W-1:0]     second_group,
    input  logic [pfas_pkg::COST_W-1:0]      same_cost,
    input  logic [pfas_pkg::COST_W-1:0]      differ_cost,
    input  logic                             last_entry,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pfas_pkg::OUT_MASK_W-1:0]  flip_mask,
    output logic [pfas_pkg::SCORE_W-1:0]     best_score
);
    import pfas_pkg::*;

    logic [CFG_W-1:0] group_count_reg;
    logic [CFG_W-1:0] group_count_next;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    pfas_cmd_t        push_cmd;
    pfas_cmd_t        pop_cmd;

    // Group count register, always ready
    assign cfg_ready        = 1'b1;
    assign group_count_next = (cfg_valid && cfg_ready) ? cfg_data : group_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= CFG_W'(1);
        end
        else
        begin
            group_count_reg <= group_count_next;
        end
    end

    pfas_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_group  (first_group),
        .second_group (second_group),
        .same_cost    (same_cost),
        .differ_cost  (differ_cost),
        .last_entry   (last_entry),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    pfas_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    pfas_back #(
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_PAIRS  (MAX_PAIRS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .group_count (group_count_reg),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .flip_mask   (flip_mask),
        .best_score  (best_score)
    );

endmodule

/* design/pfas_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pfas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/pfas_front.sv */
`timescale 1ns / 1ps
// Front end: accepts pair-cost transactions, assigns store slots and drops
// entries beyond the store. Depends on pfas_pkg.
module pfas_front #(
    parameter int MAX_PAIRS = pfas_pkg::MAX_PAIRS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pfas_pkg::GROUP_W-1:0]   first_group,
    input  logic [pfas_pkg::GROUP_W-1:0]   second_group,
    input  logic [pfas_pkg::COST_W-1:0]    same_cost,
    input  logic [pfas_pkg::COST_W-1:0]    differ_cost,
    input  logic                           last_entry,
    input  logic                           q_full,
    output logic                           q_push,
    output pfas_pkg::pfas_cmd_t            q_cmd
);
    import pfas_pkg::*;

    localparam int CW = $clog2(MAX_PAIRS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          store_ok;

    // Stall while the queue is full
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign store_ok = (count_reg < CW'(MAX_PAIRS));

    // Classify the transaction: slot, drop flag and search length
    always_comb
    begin
        q_cmd.entry.first_group  = first_group;
        q_cmd.entry.second_group = second_group;
        q_cmd.entry.same_cost    = same_cost;
        q_cmd.entry.differ_cost  = differ_cost;
        q_cmd.last_entry         = last_entry;
        q_cmd.store_ok           = store_ok;
        q_cmd.addr               = store_ok ? PAIR_ADDR_W'(count_reg)
                                            : PAIR_ADDR_W'(MAX_PAIRS - 1);
    end

    // Advance the fill count; restart it after the batch closes
    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            if (last_entry)
            begin
                count_next = '0;
            end
            else if (store_ok)
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* design/pfas_fifo.sv */
`timescale 1ns / 1ps
// Two-slot queue of classified transactions between front and back end.
// Depends on pfas_pkg.
module pfas_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pfas_pkg::pfas_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output pfas_pkg::pfas_cmd_t pop_cmd,
    output logic                empty
);
    import pfas_pkg::*;

    pfas_cmd_t   slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        do_push;
    logic        do_pop;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold the queued payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/pfas_back.sv */
`timescale 1ns / 1ps
// Back end: writes entries into the pair store and runs the exhaustive
// flip search. Depends on pfas_pkg and pfas_ram.
module pfas_back #(
    parameter int MAX_GROUPS = pfas_pkg::MAX_GROUPS_DEF,
    parameter int MAX_PAIRS  = pfas_pkg::MAX_PAIRS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [pfas_pkg::CFG_W-1:0]       group_count,
    input  logic                             q_empty,
    input  pfas_pkg::pfas_cmd_t              q_cmd,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pfas_pkg::OUT_MASK_W-1:0]  flip_mask,
    output logic [pfas_pkg::SCORE_W-1:0]     best_score
);
    import pfas_pkg::*;

    localparam int AW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int NW  = $clog2(MAX_GROUPS + 1);
    localparam int VW  = MAX_GROUPS - 1;
    localparam int VIW = (VW > 1) ? $clog2(VW) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  rd_pend_reg;
    logic                  rd_pend_next;
    logic                  rd_last_reg;
    logic                  rd_last_next;
    logic                  have_reg;
    logic                  have_next;
    logic                  issue_done_reg;
    logic                  issue_done_next;
    logic [AW-1:0]         rd_idx_reg;
    logic [AW-1:0]         rd_idx_next;
    logic [AW-1:0]         last_addr_reg;
    logic [AW-1:0]         last_addr_next;
    logic [VW-1:0]         v_reg;
    logic [VW-1:0]         v_next;
    logic [SCORE_W-1:0]    acc_reg;
    logic [SCORE_W-1:0]    acc_next;
    logic [SCORE_W-1:0]    best_reg;
    logic [SCORE_W-1:0]    best_next;
    logic [MAX_GROUPS-1:0] best_mask_reg;
    logic [MAX_GROUPS-1:0] best_mask_next;
    logic [OUT_MASK_W-1:0] out_mask_reg;
    logic [OUT_MASK_W-1:0] out_mask_next;
    logic [SCORE_W-1:0]    out_score_reg;
    logic [SCORE_W-1:0]    out_score_next;

    logic [NW-1:0]         n_groups;
    logic [MAX_GROUPS-1:0] cur_mask;
    logic [MASK_EXT_W-1:0] cur_mask_ext;
    logic [MASK_EXT_W-1:0] sel_mask_ext;
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_rdata;
    pfas_entry_t           rd_entry;
    logic [COST_W-1:0]     add_cost;
    logic [SCORE_W:0]      sum_wide;
    logic [SCORE_W-1:0]    acc_sum;
    logic                  take_new;
    logic [SCORE_W-1:0]    sel_best;
    logic [MAX_GROUPS-1:0] sel_mask;
    logic                  issuing;

    // Pair store
    pfas_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PAIRS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_cmd.addr[AW-1:0]),
        .wdata (q_cmd.entry),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = pfas_entry_t'(ram_rdata);

    // Clamp the group count into 1..MAX_GROUPS
    always_comb
    begin
        if (group_count == '0)
        begin
            n_groups = NW'(1);
        end
        else if ({1'b0, group_count} > (CFG_W + 1)'(MAX_GROUPS))
        begin
            n_groups = NW'(MAX_GROUPS);
        end
        else
        begin
            n_groups = NW'(group_count);
        end
    end

    // Map the descending counter onto groups: group 1 takes the top bit
    always_comb
    begin
        cur_mask = '0;
        for (int g = 1; g < MAX_GROUPS; g++)
        begin
            if (g < int'(n_groups))
            begin
                cur_mask[g] = v_reg[VIW'(int'(n_groups) - 1 - g)];
            end
        end
    end

    assign cur_mask_ext = MASK_EXT_W'(cur_mask);

    // Cost of the entry just read, saturating accumulation
    assign add_cost = (cur_mask_ext[rd_entry.first_group] == cur_mask_ext[rd_entry.second_group])
                      ? rd_entry.same_cost : rd_entry.differ_cost;
    assign sum_wide = {1'b0, acc_reg} + (SCORE_W + 1)'(add_cost);
    assign acc_sum  = sum_wide[SCORE_W] ? {SCORE_W{1'b1}} : sum_wide[SCORE_W-1:0];

    // Keep the earliest vector of least cost
    assign take_new     = !have_reg || (acc_reg < best_reg);
    assign sel_best     = take_new ? acc_reg : best_reg;
    assign sel_mask     = take_new ? cur_mask : best_mask_reg;
    assign sel_mask_ext = MASK_EXT_W'(sel_mask);

    assign issuing = (state_reg == S_SUM) && !issue_done_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        have_next       = have_reg;
        issue_done_next = issue_done_reg;
        rd_idx_next     = rd_idx_reg;
        last_addr_next  = last_addr_reg;
        v_next          = v_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        best_mask_next  = best_mask_reg;
        out_mask_next   = out_mask_reg;
        out_score_next  = out_score_reg;
        rd_pend_next    = issuing;
        rd_last_next    = issuing && (rd_idx_reg == last_addr_reg);
        q_pop           = 1'b0;
        ram_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop  = 1'b1;
                    ram_we = q_cmd.store_ok;
                    if (q_cmd.last_entry)
                    begin
                        if (n_groups == NW'(1))
                        begin
                            out_mask_next  = '0;
                            out_score_next = '0;
                            out_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            v_next          = {VW{1'b1}} >> (MAX_GROUPS - int'(n_groups));
                            have_next       = 1'b0;
                            last_addr_next  = q_cmd.addr[AW-1:0];
                            rd_idx_next     = '0;
                            issue_done_next = 1'b0;
                            acc_next        = '0;
                            state_next      = S_SUM;
                        end
                    end
                end
            end
            S_SUM:
            begin
                // Issue one read per cycle, sum one entry per cycle
                if (!issue_done_reg)
                begin
                    rd_idx_next     = rd_idx_reg + AW'(1);
                    issue_done_next = (rd_idx_reg == last_addr_reg);
                end
                if (rd_pend_reg)
                begin
                    acc_next = acc_sum;
                    if (rd_last_reg)
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                have_next      = 1'b1;
                best_next      = sel_best;
                best_mask_next = sel_mask;
                if (v_reg == '0)
                begin
                    out_mask_next  = sel_mask_ext[OUT_MASK_W-1:0];
                    out_score_next = sel_best;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    v_next          = v_reg - VW'(1);
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    acc_next        = '0;
                    state_next      = S_SUM;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            have_reg      <= have_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        issue_done_reg <= issue_done_next;
        rd_idx_reg     <= rd_idx_next;
        last_addr_reg  <= last_addr_next;
        v_reg          <= v_next;
        acc_reg        <= acc_next;
        best_reg       <= best_next;
        best_mask_reg  <= best_mask_next;
        out_mask_reg   <= out_mask_next;
        out_score_reg  <= out_score_next;
    end

    assign out_valid  = out_valid_reg;
    assign flip_mask  = out_mask_reg;
    assign best_score = out_score_reg;

`ifndef SYNTHESIS
    // A result is shown only while the sequencer waits in its output state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_OUT))
        else $error("result valid outside output state");

    // Read data is consumed only while summing
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_SUM))
        else $error("store read pending outside summing");

    // Group 0 is never flipped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !out_mask_reg[0])
        else $error("group 0 flipped in result");

    // Reads never run past the last stored entry
    assert property (@(posedge clk) disable iff (!rst_n)
        issuing |-> (rd_idx_reg <= last_addr_reg))
        else $error("store read beyond last entry");

    // A compare with vectors left goes back to summing
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CMP) && (v_reg != '0)) |=> (state_reg == S_SUM))
        else $error("search ended early");
`endif

endmodule

/* sim/tb_pairwise_flip_assignment_search.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pairwise_flip_assignment_search: a directed table, then random
// batches of pair-cost entries. Each untyped search result is predicted by a flip-vector model here.
// Depends on pfas_pkg and the RTL of the block.
module tb_pairwise_flip_assignment_search;

    import pfas_pkg::*;

    localparam int NUM_GROUPS      = MAX_GROUPS_DEF;
    localparam int NUM_PAIRS       = MAX_PAIRS_DEF;
    localparam int ITEM_TARGET     = 1650;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int CYCLE_LIMIT     = 12000000;

    typedef struct packed {
        logic [OUT_MASK_W-1:0] mask;
        logic [SCORE_W-1:0]    score;
    } flip_result_t;

    typedef enum logic {ROW_CFG, ROW_ENTRY} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [CFG_W-1:0] count;
        pfas_entry_t      entry;
        logic             last;
        logic             typed;
        flip_result_t     result;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [GROUP_W-1:0]    first_group;
    logic [GROUP_W-1:0]    second_group;
    logic [COST_W-1:0]     same_cost;
    logic [COST_W-1:0]     differ_cost;
    logic                  last_entry;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_MASK_W-1:0] flip_mask;
    logic [SCORE_W-1:0]    best_score;

    // Shadow copy of the entry store and the group count
    pfas_entry_t      stored_pairs [NUM_PAIRS];
    int unsigned      stored_count;
    logic [CFG_W-1:0] searched_groups;

    flip_result_t awaited_flips [$];
    stim_row_t    directed_rows [$];
    int unsigned  errors;
    int unsigned  items_sent;
    int unsigned  zero_gap_items;
    int unsigned  cycle_count;
    bit           hold_off_req;

    pairwise_flip_assignment_search uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_group  (first_group),
        .second_group (second_group),
        .same_cost    (same_cost),
        .differ_cost  (differ_cost),
        .last_entry   (last_entry),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .flip_mask    (flip_mask),
        .best_score   (best_score)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Clamp the register to the searched range: zero reads as one, above the maximum saturates
    function automatic int effective_groups(logic [CFG_W-1:0] groups);
        if (groups == 0)
            return 1;
        if (groups > NUM_GROUPS)
            return NUM_GROUPS;
        return int'(groups);
    endfunction

    // A group at or above the count is never flipped
    function automatic logic flip_of(logic [MASK_EXT_W-1:0] mask, logic [GROUP_W-1:0] g, int n);
        return (g < n) ? mask[g] : 1'b0;
    endfunction

    // Sum the stored entries for one flip vector, saturating at the top of the score range
    function automatic logic [SCORE_W-1:0] vector_total(logic [MASK_EXT_W-1:0] mask, int n);
        logic [SCORE_W:0] acc;
        int unsigned      i;
        acc = '0;
        for (i = 0; i < stored_count; i++)
        begin
            if (flip_of(mask, stored_pairs[i].first_group, n) ==
                flip_of(mask, stored_pairs[i].second_group, n))
                acc = acc + stored_pairs[i].same_cost;
            else
                acc = acc + stored_pairs[i].differ_cost;
            if (acc[SCORE_W])
                acc = {1'b0, {SCORE_W{1'b1}}};
        end
        return acc[SCORE_W-1:0];
    endfunction

    // Walk the vectors with group 1 as the top bit, flip tried first; earliest least cost wins
    function automatic flip_result_t search_least_flip(logic [CFG_W-1:0] groups);
        flip_result_t          best;
        logic [MASK_EXT_W-1:0] mask;
        logic [SCORE_W-1:0]    total;
        int                    n;
        int                    k;
        int                    g;
        int                    v;
        int                    span;
        n = effective_groups(groups);
        best = '0;
        if (n > 1)
        begin
            span = 1 << (n - 1);
            for (k = 0; k < span; k++)
            begin
                v = span - 1 - k;
                mask = '0;
                for (g = 1; g < n; g++)
                    mask[g] = 1'((v >> (n - 1 - g)) & 1);
                total = vector_total(mask, n);
                if (k == 0 || total < best.score)
                begin
                    best.score = total;
                    best.mask  = mask[OUT_MASK_W-1:0];
                end
            end
        end
        return best;
    endfunction

    // Mostly short gaps, some long, and now and then a run of back-to-back transactions
    function automatic int unsigned next_gap();
        int unsigned r;
        if (zero_gap_items > 0)
        begin
            zero_gap_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            zero_gap_items = $urandom_range(20, 60);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly groups inside the searched range, some past it up to the field's top
    function automatic logic [GROUP_W-1:0] pick_group(int n);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return GROUP_W'($urandom_range(0, n - 1));
        if (r < 90)
            return GROUP_W'($urandom_range(0, NUM_GROUPS - 1));
        return GROUP_W'($urandom_range(0, (1 << GROUP_W) - 1));
    endfunction

    // Small costs give plenty of ties; the rest spread over the field with its extremes
    function automatic logic [COST_W-1:0] pick_cost();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return COST_W'($urandom_range(0, 3));
        if (r < 60)
            return COST_W'($urandom_range(0, 255));
        if (r < 90)
            return COST_W'($urandom_range(0, (1 << COST_W) - 1));
        return (r < 95) ? '0 : '1;
    endfunction

    task automatic add_cfg_row(input logic [CFG_W-1:0] count);
        stim_row_t row;
        row = '{kind: ROW_CFG, count: count, entry: '0, last: 1'b0, typed: 1'b0, result: '0};
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_entry_row(input logic [GROUP_W-1:0] g1, input logic [GROUP_W-1:0] g2,
                                 input logic [COST_W-1:0] same, input logic [COST_W-1:0] diff,
                                 input logic last, input logic typed,
                                 input logic [OUT_MASK_W-1:0] mask,
                                 input logic [SCORE_W-1:0] score);
        stim_row_t row;
        row.kind   = ROW_ENTRY;
        row.count  = '0;
        row.entry  = '{first_group: g1, second_group: g2, same_cost: same, differ_cost: diff};
        row.last   = last;
        row.typed  = typed;
        row.result = '{mask: mask, score: score};
        directed_rows = {directed_rows, row};
    endtask

    // Offer one entry, hold it until taken, then update the shadow store
    task automatic send_entry(input pfas_entry_t e, input logic last,
                              input logic typed, input flip_result_t typed_result);
        int unsigned  gap;
        flip_result_t want;
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_group  <= e.first_group;
        second_group <= e.second_group;
        same_cost    <= e.same_cost;
        differ_cost  <= e.differ_cost;
        last_entry   <= last;
        do @(posedge clk); while (in_stall);
        items_sent++;
        // Entries past a full store are dropped, but a dropped closing entry still searches
        if (stored_count < NUM_PAIRS)
        begin
            stored_pairs[stored_count] = e;
            stored_count++;
        end
        if (last)
        begin
            want = typed ? typed_result : search_least_flip(searched_groups);
            awaited_flips = {awaited_flips, want};
            stored_count = 0;
        end
    endtask

    // Wait for the block to go idle, then write the group count
    task automatic write_group_count(input logic [CFG_W-1:0] count);
        in_valid <= 1'b0;
        while (awaited_flips.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        searched_groups = count;
    endtask

    task automatic send_batch(input int unsigned size);
        pfas_entry_t e;
        int          n;
        int unsigned i;
        n = effective_groups(searched_groups);
        for (i = 0; i < size; i++)
        begin
            e.first_group  = pick_group(n);
            e.second_group = pick_group(n);
            e.same_cost    = pick_cost();
            e.differ_cost  = pick_cost();
            send_entry(e, i == size - 1, 1'b0, '0);
        end
    endtask

    // Receiver stall pattern; a requested hold-off is counted out here
    initial
    begin : result_stall
        int unsigned run_left;
        int unsigned r;
        out_stall = 1'b0;
        run_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                run_left = 0;
            end
            else if (run_left > 0)
                run_left--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    out_stall <= 1'b0;
                    run_left = $urandom_range(0, 12);
                end
                else if (r < 85)
                begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(0, 3);
                end
                else if (r < 93)
                begin
                    out_stall <= 1'b0;
                    run_left = $urandom_range(50, 200);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(20, 80);
                end
            end
        end
    end

    // Compare each result transaction with the oldest awaited one
    always @(posedge clk)
    begin : result_check
        flip_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_flips.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual mask %h score %h",
                         $time, flip_mask, best_score);
            end
            else
            begin
                want = awaited_flips.pop_front();
                if (flip_mask !== want.mask)
                begin
                    errors++;
                    $display("%0t: flip_mask expected %h actual %h", $time, want.mask, flip_mask);
                end
                if (best_score !== want.score)
                begin
                    errors++;
                    $display("%0t: best_score expected %h actual %h",
                             $time, want.score, best_score);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_pairwise_flip_assignment_search: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned idx;
        int unsigned batches;
        int unsigned phase;
        int unsigned size;
        int unsigned r;
        stim_row_t   row;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        first_group    = '0;
        second_group   = '0;
        same_cost      = '0;
        differ_cost    = '0;
        last_entry     = 1'b0;
        errors         = 0;
        items_sent     = 0;
        zero_gap_items = 0;
        cycle_count    = 0;
        hold_off_req   = 1'b0;
        stored_count   = 0;
        searched_groups = 4'd1;

        // One group after reset: zero result whatever the costs
        add_entry_row(4'd0, 4'd1, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 10'h000, 32'd0);
        // Zero count reads as one group
        add_cfg_row(4'd0);
        add_entry_row(4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 10'h000, 32'd0);
        // Two groups: flipping group 1 picks the differ costs
        add_cfg_row(4'd2);
        add_entry_row(4'd0, 4'd1, 16'd100, 16'd5, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd1, 4'd0, 16'd7, 16'd9, 1'b1, 1'b1, 10'h002, 32'd14);
        // Tie: the flipped vector comes first and stays
        add_entry_row(4'd0, 4'd1, 16'd3, 16'd3, 1'b1, 1'b1, 10'h002, 32'd3);
        // Count above the maximum saturates; groups past the count stay unflipped
        add_cfg_row(4'd15);
        add_entry_row(4'd9, 4'd15, 16'd0, 16'd1000, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd15, 4'd14, 16'hFFFF, 16'd0, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd0, 4'd9, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0);
        // All costs zero: the first vector, everything flipped, wins
        add_cfg_row(4'd10);
        add_entry_row(4'd3, 4'd4, 16'd0, 16'd0, 1'b1, 1'b1, 10'h3FE, 32'd0);
        add_cfg_row(4'd3);
        add_entry_row(4'd1, 4'd2, 16'hFFFF, 16'd0, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd2, 4'd1, 16'hFFFF, 16'd0, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd0, 4'd2, 16'd0, 16'hFFFF, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd12, 4'd1, 16'd1234, 16'd4321, 1'b1, 1'b0, '0, '0);
        add_cfg_row(4'd8);
        add_entry_row(4'd7, 4'd0, 16'hAAAA, 16'h5555, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd8, 4'd5, 16'h5555, 16'hAAAA, 1'b1, 1'b0, '0, '0);
        // Back to one group: stored entries are not summed
        add_cfg_row(4'd1);
        add_entry_row(4'd6, 4'd9, 16'd1, 16'd2, 1'b0, 1'b0, '0, '0);
        add_entry_row(4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 10'h000, 32'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (idx = 0; idx < directed_rows.size(); idx++)
        begin
            row = directed_rows[idx];
            if (row.kind == ROW_CFG)
                write_group_count(row.count);
            else
                send_entry(row.entry, row.last, row.typed, row.result);
        end

        // Random phases, each with its own group count and several batches
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 2)
            begin
                // Hold the result side off while entries keep coming, so the input stalls
                write_group_count(4'd3);
                hold_off_req = 1'b1;
                zero_gap_items = 120;
            end
            else if (phase == 4)
            begin
                // Overfill the store at the widest search; the closing entry is dropped
                write_group_count(4'd10);
                send_batch(NUM_PAIRS + 7);
            end
            else if (phase == 6)
            begin
                write_group_count(4'd3);
                send_batch(NUM_PAIRS);
            end
            else
            begin
                r = $urandom_range(0, 99);
                write_group_count(r < 50 ? CFG_W'($urandom_range(0, 15))
                                         : CFG_W'($urandom_range(2, 7)));
            end
            batches = $urandom_range(3, 10);
            repeat (batches)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    size = $urandom_range(1, 6);
                else if (r < 95)
                    size = $urandom_range(7, 20);
                else
                    size = $urandom_range(21, 48);
                send_batch(size);
            end
            phase++;
        end

        // Drain outstanding results
        in_valid <= 1'b0;
        while (awaited_flips.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_pairwise_flip_assignment_search: PASS");
        else
            $display("tb_pairwise_flip_assignment_search: FAIL");
        $finish;
    end

endmodule

/* pairwise_flip_assignment_search.f */
design/pfas_pkg.sv
design/pfas_ram.sv
design/pfas_front.sv
design/pfas_fifo.sv
design/pfas_back.sv
design/pairwise_flip_assignment_search.sv
sim/tb_pairwise_flip_assignment_search.sv
